FILE: rtl/core/ntlr_pkg.sv
`timescale 1ns / 1ps

package ntlr_pkg;

    // item commands
    localparam logic [1:0] CMD_ANNOUNCE = 2'd0;
    localparam logic [1:0] CMD_FORWARD  = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SINK_ADDRESS   = 2'd0;
    localparam logic [1:0] REG_RSSI_OFFSET    = 2'd1;
    localparam logic [1:0] REG_RSSI_FLOOR     = 2'd2;
    localparam logic [1:0] REG_ENTRY_LIFETIME = 2'd3;

    localparam int unsigned PADDR_W = 4;

    localparam logic [15:0]        SINK_ADDRESS_RESET   = 16'd32768;
    localparam logic signed [7:0]  RSSI_OFFSET_RESET    = -8'sd45;
    localparam logic signed [7:0]  RSSI_FLOOR_RESET     = -8'sd79;
    localparam logic [15:0]        ENTRY_LIFETIME_RESET = 16'd120;
    localparam logic [6:0]         NODE_LAYER_RESET     = 7'd50;
    localparam logic [6:0]         SINK_LAYER           = 7'd1;

    typedef struct packed {
        logic [15:0]       sink_address;
        logic signed [7:0] rssi_offset;
        logic signed [7:0] rssi_floor;
        logic [15:0]       entry_lifetime;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [15:0]       sender_address;
        logic [6:0]        sender_layer;
        logic signed [7:0] raw_rssi;
    } in_item_t;

    typedef struct packed {
        logic        next_hop_valid;
        logic [15:0] next_hop_address;
        logic [6:0]  own_layer;
        logic [4:0]  neighbor_count;
        logic        announcement_accepted;
    } out_item_t;

    typedef struct packed {
        logic [15:0] address;
        logic [6:0]  layer;
        logic [15:0] timer;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/ntlr_if.sv
`timescale 1ns / 1ps

interface ntlr_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [15:0]       sender_address;
    logic [6:0]        sender_layer;
    logic signed [7:0] raw_rssi;

    modport source (output valid, command, sender_address, sender_layer, raw_rssi,
                    input ready);
    modport sink   (input valid, command, sender_address, sender_layer, raw_rssi,
                    output ready);
endinterface

interface ntlr_rsp_if;
    logic        valid;
    logic        ready;
    logic        next_hop_valid;
    logic [15:0] next_hop_address;
    logic [6:0]  own_layer;
    logic [4:0]  neighbor_count;
    logic        announcement_accepted;

    modport source (output valid, next_hop_valid, next_hop_address, own_layer,
                    neighbor_count, announcement_accepted, input ready);
    modport sink   (input valid, next_hop_valid, next_hop_address, own_layer,
                    neighbor_count, announcement_accepted, output ready);
endinterface

FILE: rtl/core/neighbor_table_layer_router_core.sv
`timescale 1ns / 1ps

// Neighbor table with hop layer for gradient routing.
// req (sink side): one item per command: announcement, forward request or tick.
// rsp (source side): exactly one result item per accepted request item.
// APB port: sink_address 0x0, rssi_offset 0x4, rssi_floor 0x8,
// entry_lifetime 0xC; write only while the block is idle.
// Timing: an item is taken in the idle state, then the table memory is walked one
// entry per cycle (one read port, registered read data), then the result is
// committed in the commit state. A rejected announcement, an unknown command or
// an empty table skips the walk. A refresh hit or the sink entry ends the walk
// early. One item is in work at a time; req.ready is high only between items.
// The result sits in an output register, so the next item is taken while rsp
// waits; if rsp stalls, the following item holds in its commit state until the
// register frees.
// Reset: empty table, own layer 50, registers at their defaults; the table
// memory needs no clearing since only the filled prefix is ever read.
module neighbor_table_layer_router_core
    import ntlr_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    ntlr_req_if.sink           req,
    ntlr_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    in_item_t   req_item;
    out_item_t  rsp_item;
    logic       in_ready;
    logic       rsp_valid;

    assign req_item = '{command:        req.command,
                        sender_address: req.sender_address,
                        sender_layer:   req.sender_layer,
                        raw_rssi:       req.raw_rssi};

    assign req.ready                 = in_ready;
    assign rsp.valid                 = rsp_valid;
    assign rsp.next_hop_valid        = rsp_item.next_hop_valid;
    assign rsp.next_hop_address      = rsp_item.next_hop_address;
    assign rsp.own_layer             = rsp_item.own_layer;
    assign rsp.neighbor_count        = rsp_item.neighbor_count;
    assign rsp.announcement_accepted = rsp_item.announcement_accepted;

    ntlr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ntlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ntlr_datapath #(
        .DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .req_item  (req_item),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .rsp_item  (rsp_item)
    );

endmodule

FILE: rtl/core/ntlr_cfg_regs.sv
`timescale 1ns / 1ps

module ntlr_cfg_regs
    import ntlr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SINK_ADDRESS:   cfg_next.sink_address   = pwdata[15:0];
                REG_RSSI_OFFSET:    cfg_next.rssi_offset    = pwdata[7:0];
                REG_RSSI_FLOOR:     cfg_next.rssi_floor     = pwdata[7:0];
                REG_ENTRY_LIFETIME: cfg_next.entry_lifetime = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SINK_ADDRESS:   prdata = {16'd0, cfg_reg.sink_address};
            REG_RSSI_OFFSET:    prdata = 32'(cfg_reg.rssi_offset);
            REG_RSSI_FLOOR:     prdata = 32'(cfg_reg.rssi_floor);
            REG_ENTRY_LIFETIME: prdata = {16'd0, cfg_reg.entry_lifetime};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sink_address   <= SINK_ADDRESS_RESET;
            cfg_reg.rssi_offset    <= RSSI_OFFSET_RESET;
            cfg_reg.rssi_floor     <= RSSI_FLOOR_RESET;
            cfg_reg.entry_lifetime <= ENTRY_LIFETIME_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/ntlr_ctrl.sv
`timescale 1ns / 1ps

module ntlr_ctrl
    import ntlr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // wait for the output register to drain
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/core/ntlr_datapath.sv
`timescale 1ns / 1ps

module ntlr_datapath
    import ntlr_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    input  cfg_t       cfg,
    input  in_item_t   req_item,
    output dp_status_t status,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output out_item_t  rsp_item
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    entry_t mem [DEPTH];

    // item context
    logic [1:0]  cmd_reg,   cmd_next;
    logic [15:0] addr_reg,  addr_next;
    logic [6:0]  layer_reg, layer_next;
    logic        pass_reg,  pass_next;

    logic [6:0]    node_layer_reg, node_layer_next;
    logic [CW-1:0] count_reg,      count_next;

    // scan state
    logic [CW-1:0] rd_ptr_reg,  rd_ptr_next;
    logic          rd_vld_reg,  rd_vld_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic [CW-1:0] w_reg,       w_next;
    logic          hit_reg,     hit_next;
    logic          sink_reg,    sink_next;
    logic          low_reg,     low_next;
    logic [15:0]   low_addr_reg,   low_addr_next;
    logic [15:0]   first_addr_reg, first_addr_next;
    entry_t        rd_data_reg;

    logic      rsp_valid_reg, rsp_valid_next;
    out_item_t rsp_item_reg,  rsp_item_next;

    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    entry_t            mem_wd;
    logic              rd_issue;
    logic signed [7:0] rss;
    logic              pass_in;
    logic              stop;
    logic              scan_cmd;
    logic              can_issue;
    logic [CW-1:0]     count_fin;

    assign rss     = 8'(req_item.raw_rssi + cfg.rssi_offset);
    assign pass_in = (req_item.command == CMD_ANNOUNCE) && (rss > cfg.rssi_floor);

    assign stop      = hit_reg || sink_reg;
    assign scan_cmd  = ((cmd_reg == CMD_ANNOUNCE) && pass_reg) ||
                       (cmd_reg == CMD_FORWARD) || (cmd_reg == CMD_TICK);
    assign can_issue = scan_cmd && !stop && (rd_ptr_reg < count_reg);

    assign status.scan_done = !rd_vld_reg && !can_issue;
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    always_comb
    begin
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        layer_next      = layer_reg;
        pass_next       = pass_reg;
        node_layer_next = node_layer_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_vld_next     = rd_vld_reg;
        chk_idx_next    = chk_idx_reg;
        w_next          = w_reg;
        hit_next        = hit_reg;
        sink_next       = sink_reg;
        low_next        = low_reg;
        low_addr_next   = low_addr_reg;
        first_addr_next = first_addr_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_item_next   = rsp_item_reg;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;
        rd_issue        = 1'b0;
        count_fin       = count_reg;

        if (cmd.latch)
        begin
            cmd_next    = req_item.command;
            addr_next   = req_item.sender_address;
            layer_next  = req_item.sender_layer;
            pass_next   = pass_in;
            rd_ptr_next = '0;
            rd_vld_next = 1'b0;
            w_next      = '0;
            hit_next    = 1'b0;
            sink_next   = 1'b0;
            low_next    = 1'b0;
            if (pass_in)
            begin
                if (req_item.sender_address == cfg.sink_address)
                    node_layer_next = SINK_LAYER;
                else if (node_layer_reg > req_item.sender_layer)
                    node_layer_next = req_item.sender_layer + 7'd1;
            end
        end

        if (cmd.scan)
        begin
            // read side: one entry issued per cycle, its data checked from the read data register
            if (can_issue)
            begin
                rd_issue     = 1'b1;
                rd_ptr_next  = rd_ptr_reg + CW'(1);
                chk_idx_next = rd_ptr_reg[IW-1:0];
                rd_vld_next  = 1'b1;
            end
            else
            begin
                rd_vld_next = 1'b0;
            end

            if (rd_vld_reg)
            begin
                unique case (cmd_reg)
                    CMD_ANNOUNCE:
                    begin
                        if (!hit_reg && (rd_data_reg.address == addr_reg))
                        begin
                            mem_we   = 1'b1;
                            mem_wa   = chk_idx_reg;
                            mem_wd   = '{address: addr_reg, layer: layer_reg,
                                         timer: cfg.entry_lifetime};
                            hit_next = 1'b1;
                        end
                    end
                    CMD_FORWARD:
                    begin
                        if (chk_idx_reg == '0)
                            first_addr_next = rd_data_reg.address;
                        if (!sink_reg)
                        begin
                            if (rd_data_reg.address == cfg.sink_address)
                            begin
                                sink_next = 1'b1;
                            end
                            else if (!low_reg && (rd_data_reg.layer < node_layer_reg))
                            begin
                                low_next      = 1'b1;
                                low_addr_next = rd_data_reg.address;
                            end
                        end
                    end
                    CMD_TICK:
                    begin
                        // survivors are packed toward the front, order kept
                        if (rd_data_reg.timer > 16'd1)
                        begin
                            mem_we = 1'b1;
                            mem_wa = w_reg[IW-1:0];
                            mem_wd = '{address: rd_data_reg.address,
                                       layer:   rd_data_reg.layer,
                                       timer:   rd_data_reg.timer - 16'd1};
                            w_next = w_reg + CW'(1);
                        end
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
        end

        if (cmd.commit)
        begin
            if ((cmd_reg == CMD_ANNOUNCE) && pass_reg && !hit_reg && (count_reg < DEPTH_C))
            begin
                mem_we    = 1'b1;
                mem_wa    = count_reg[IW-1:0];
                mem_wd    = '{address: addr_reg, layer: layer_reg,
                              timer: cfg.entry_lifetime};
                count_fin = count_reg + CW'(1);
            end
            else if (cmd_reg == CMD_TICK)
            begin
                count_fin = w_reg;
            end
            count_next = count_fin;

            rsp_item_next.next_hop_valid        = (cmd_reg == CMD_FORWARD) && (count_reg != '0);
            rsp_item_next.next_hop_address      = '0;
            if (rsp_item_next.next_hop_valid)
            begin
                priority if (sink_reg)
                    rsp_item_next.next_hop_address = cfg.sink_address;
                else if (low_reg)
                    rsp_item_next.next_hop_address = low_addr_reg;
                else
                    rsp_item_next.next_hop_address = first_addr_reg;
            end
            rsp_item_next.own_layer             = node_layer_reg;
            rsp_item_next.neighbor_count        = 5'(count_fin);
            rsp_item_next.announcement_accepted = (cmd_reg == CMD_ANNOUNCE) && pass_reg;
            rsp_valid_next                      = 1'b1;
        end
        else if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (rd_issue)
            rd_data_reg <= mem[rd_ptr_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        layer_reg      <= layer_next;
        chk_idx_reg    <= chk_idx_next;
        low_addr_reg   <= low_addr_next;
        first_addr_reg <= first_addr_next;
        rsp_item_reg   <= rsp_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg       <= 1'b0;
            node_layer_reg <= NODE_LAYER_RESET;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            w_reg          <= '0;
            hit_reg        <= 1'b0;
            sink_reg       <= 1'b0;
            low_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            pass_reg       <= pass_next;
            node_layer_reg <= node_layer_next;
            count_reg      <= count_next;
            rd_ptr_reg     <= rd_ptr_next;
            rd_vld_reg     <= rd_vld_next;
            w_reg          <= w_next;
            hit_reg        <= hit_next;
            sink_reg       <= sink_next;
            low_reg        <= low_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("neighbor count above table depth");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(mem_wa) <= count_reg))
        else $error("table write beyond filled region");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && rd_vld_reg && (cmd_reg == CMD_TICK)) |-> (w_reg <= CW'(chk_idx_reg)))
        else $error("tick compaction write pointer overtook read");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid_reg)
        else $error("committed item produced no result");

endmodule

FILE: tb/neighbor_table_layer_router_core_test.sv
`timescale 1ns / 1ps

module neighbor_table_layer_router_core_test;
    import ntlr_pkg::*;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int          POOL_SIZE = 20;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ntlr_req_if req_ch ();
    ntlr_rsp_if rsp_ch ();

    neighbor_table_layer_router_core #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block: table in insertion order, own layer, registers
    logic [15:0] tbl_addr  [TABLE_DEPTH];
    logic [6:0]  tbl_layer [TABLE_DEPTH];
    logic [15:0] tbl_timer [TABLE_DEPTH];
    int          tbl_count;
    logic [6:0]  my_layer;
    cfg_t        route_cfg;

    out_item_t   route_results_due [$];
    out_item_t   route_want;
    logic [15:0] addr_pool [POOL_SIZE];

    bit idling;
    int stall_len;
    int cycle_count;
    int fail_count;
    int items_sent;
    int accepted_count;
    int hops_found;
    int expired_count;
    int full_drops;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** neighbor_table_layer_router_core: FAILED **");
            $finish;
        end
    end

    // result side back-pressure
    always begin
        @(negedge clk);
        if (idling && $urandom_range(0, 5) == 0) begin
            stall_len = $urandom_range(1, 17);
            rsp_ch.ready <= 1'b0;
            repeat (stall_len - 1) @(negedge clk);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (route_results_due.size() == 0) begin
                $error("result item with nothing pending");
                fail_count++;
            end else begin
                route_want = route_results_due.pop_front();
                check_field("next_hop_valid", 16'(route_want.next_hop_valid),
                            16'(rsp_ch.next_hop_valid));
                check_field("next_hop_address", route_want.next_hop_address,
                            rsp_ch.next_hop_address);
                check_field("own_layer", 16'(route_want.own_layer),
                            16'(rsp_ch.own_layer));
                check_field("neighbor_count", 16'(route_want.neighbor_count),
                            16'(rsp_ch.neighbor_count));
                check_field("announcement_accepted",
                            16'(route_want.announcement_accepted),
                            16'(rsp_ch.announcement_accepted));
            end
        end
    end

    function automatic out_item_t predict_route_result(input in_item_t it);
        out_item_t         r;
        logic signed [7:0] strength;
        logic signed [7:0] floor_v;
        int                hit;
        int                w;
        int                i;
        r = '0;
        case (it.command)
            CMD_ANNOUNCE: begin
                strength = it.raw_rssi + route_cfg.rssi_offset;
                floor_v  = route_cfg.rssi_floor;
                if (strength > floor_v) begin
                    r.announcement_accepted = 1'b1;
                    accepted_count++;
                    if (it.sender_address == route_cfg.sink_address)
                        my_layer = SINK_LAYER;
                    else if (my_layer > it.sender_layer)
                        my_layer = it.sender_layer + 7'd1;
                    hit = -1;
                    for (i = 0; i < tbl_count; i++)
                        if (hit < 0 && tbl_addr[i] == it.sender_address)
                            hit = i;
                    if (hit >= 0) begin
                        tbl_layer[hit] = it.sender_layer;
                        tbl_timer[hit] = route_cfg.entry_lifetime;
                    end else if (tbl_count < TABLE_DEPTH) begin
                        tbl_addr[tbl_count]  = it.sender_address;
                        tbl_layer[tbl_count] = it.sender_layer;
                        tbl_timer[tbl_count] = route_cfg.entry_lifetime;
                        tbl_count++;
                    end else begin
                        full_drops++;
                    end
                end
            end
            CMD_FORWARD: begin
                if (tbl_count > 0) begin
                    // sink first, then first lower layer, then the oldest
                    hit = -1;
                    for (i = 0; i < tbl_count; i++)
                        if (hit < 0 && tbl_addr[i] == route_cfg.sink_address)
                            hit = i;
                    for (i = 0; i < tbl_count; i++)
                        if (hit < 0 && tbl_layer[i] < my_layer)
                            hit = i;
                    if (hit < 0)
                        hit = 0;
                    r.next_hop_valid   = 1'b1;
                    r.next_hop_address = tbl_addr[hit];
                    hops_found++;
                end
            end
            CMD_TICK: begin
                w = 0;
                for (i = 0; i < tbl_count; i++) begin
                    if (tbl_timer[i] > 16'd1) begin
                        tbl_addr[w]  = tbl_addr[i];
                        tbl_layer[w] = tbl_layer[i];
                        tbl_timer[w] = tbl_timer[i] - 16'd1;
                        w++;
                    end else begin
                        expired_count++;
                    end
                end
                tbl_count = w;
            end
            default: ;
        endcase
        r.own_layer      = my_layer;
        r.neighbor_count = 5'(tbl_count);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [6:0] layer, input logic signed [7:0] raw);
        in_item_t it;
        int       gap;
        it.command        = cmd;
        it.sender_address = addr;
        it.sender_layer   = layer;
        it.raw_rssi       = raw;
        gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        @(negedge clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.sender_address <= addr;
        req_ch.sender_layer   <= layer;
        req_ch.raw_rssi       <= raw;
        do @(posedge clk); while (!req_ch.ready);
        route_results_due.push_back(predict_route_result(it));
        items_sent++;
    endtask

    // every item yields a result, so an empty queue means the block is idle
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (route_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_SINK_ADDRESS:   route_cfg.sink_address   = val[15:0];
            REG_RSSI_OFFSET:    route_cfg.rssi_offset    = val[7:0];
            REG_RSSI_FLOOR:     route_cfg.rssi_floor     = val[7:0];
            REG_ENTRY_LIFETIME: route_cfg.entry_lifetime = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] sink, input logic signed [7:0] offset,
                              input logic signed [7:0] floor_v, input logic [15:0] timeout);
        wait_idle();
        write_reg(REG_SINK_ADDRESS, {16'h0, sink});
        write_reg(REG_RSSI_OFFSET, {{24{offset[7]}}, offset});
        write_reg(REG_RSSI_FLOOR, {{24{floor_v[7]}}, floor_v});
        write_reg(REG_ENTRY_LIFETIME, {16'h0, timeout});
    endtask

    function automatic logic [15:0] pick_address();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return route_cfg.sink_address;
        else if (sel < 4)
            return 16'($urandom_range(0, 65535));
        return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic run_random(input int n, input int announce_pct, input bit allow_idle);
        int         k;
        int         r;
        logic [1:0] cmd;
        logic [6:0] layer;
        for (k = 0; k < n; k++) begin
            idling = allow_idle && ((k / 25) % 3 != 2);
            r = $urandom_range(0, 99);
            if (r < announce_pct)
                cmd = CMD_ANNOUNCE;
            else if (r < announce_pct + (100 - announce_pct) / 2)
                cmd = CMD_FORWARD;
            else
                cmd = CMD_TICK;
            layer = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(0, 99));
            send_item(cmd, pick_address(), layer, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_empty_table();
        send_item(CMD_FORWARD, 16'h0000, 7'd0, 8'sd0);
        send_item(CMD_TICK, 16'h0000, 7'd0, 8'sd0);
        send_item(CMD_UNUSED, 16'hFFFF, 7'd99, -8'sd1);
    endtask

    task automatic test_announcements();
        // -34 - 45 lands exactly on the floor
        send_item(CMD_ANNOUNCE, 16'h1234, 7'd60, -8'sd34);
        send_item(CMD_ANNOUNCE, 16'h1234, 7'd60, -8'sd128);
        send_item(CMD_ANNOUNCE, 16'h1234, 7'd60, -8'sd33);
        send_item(CMD_ANNOUNCE, 16'hFFFF, 7'd99, 8'sd127);
        send_item(CMD_ANNOUNCE, 16'h0000, 7'd70, -8'sd33);
        send_item(CMD_FORWARD, 16'h0000, 7'd0, 8'sd0);
        // refresh the last entry with a lower layer: it becomes the next hop
        send_item(CMD_ANNOUNCE, 16'h0000, 7'd30, 8'sd5);
        send_item(CMD_FORWARD, 16'h0000, 7'd0, 8'sd0);
        send_item(CMD_TICK, 16'h0000, 7'd0, 8'sd0);
        send_item(CMD_ANNOUNCE, SINK_ADDRESS_RESET, 7'd0, 8'sd0);
        send_item(CMD_FORWARD, 16'h0000, 7'd0, 8'sd0);
    endtask

    task automatic test_zero_timeout();
        set_config(SINK_ADDRESS_RESET, RSSI_OFFSET_RESET, RSSI_FLOOR_RESET, 16'd0);
        send_item(CMD_ANNOUNCE, 16'h00A5, 7'd2, 8'sd10);
        send_item(CMD_ANNOUNCE, 16'hFFFF, 7'd99, 8'sd10);
        // both zero-timer entries go, the rest keep their order
        send_item(CMD_TICK, 16'h0000, 7'd0, 8'sd0);
        send_item(CMD_FORWARD, 16'h0000, 7'd0, 8'sd0);
    endtask

    task automatic test_config_extremes();
        set_config(16'hFFFF, 8'sd127, -8'sd128, 16'd1);
        run_random(60, 50, 1'b1);
    endtask

    task automatic test_rejecting_config();
        set_config(16'h0000, -8'sd128, 8'sd127, 16'd65535);
        run_random(20, 70, 1'b1);
    endtask

    task automatic test_random_configs();
        int p;
        for (p = 0; p < 3; p++) begin
            set_config(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(128, 216)), 16'($urandom_range(2, 24)));
            run_random(80, 50, 1'b1);
        end
    endtask

    task automatic test_full_table();
        set_config(SINK_ADDRESS_RESET, RSSI_OFFSET_RESET, RSSI_FLOOR_RESET, 16'd65535);
        run_random(80, 70, 1'b1);
    endtask

    task automatic test_steady_stream();
        set_config(16'($urandom_range(0, 65535)), RSSI_OFFSET_RESET, RSSI_FLOOR_RESET, 16'd8);
        run_random(40, 50, 1'b0);
    endtask

    initial begin
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_ANNOUNCE;
        req_ch.sender_address = '0;
        req_ch.sender_layer   = '0;
        req_ch.raw_rssi       = '0;
        rsp_ch.ready          = 1'b1;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        idling                = 1'b1;
        tbl_count             = 0;
        my_layer              = NODE_LAYER_RESET;
        route_cfg.sink_address   = SINK_ADDRESS_RESET;
        route_cfg.rssi_offset    = RSSI_OFFSET_RESET;
        route_cfg.rssi_floor     = RSSI_FLOOR_RESET;
        route_cfg.entry_lifetime = ENTRY_LIFETIME_RESET;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = 16'($urandom_range(0, 65535));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_announcements();
        test_zero_timeout();
        test_config_extremes();
        test_rejecting_config();
        test_random_configs();
        test_full_table();
        test_steady_stream();

        wait_idle();
        $display("covered %0d items over 9 register settings: %0d announcements taken,",
                 items_sent, accepted_count);
        $display("%0d next hops found, %0d entries aged out, %0d dropped on a full table",
                 hops_found, expired_count, full_drops);
        if (fail_count == 0)
            $display("** neighbor_table_layer_router_core: PASSED **");
        else
            $display("** neighbor_table_layer_router_core: FAILED **");
        $finish;
    end

endmodule
